>>> rtl/pftc_pkg.sv
// ---------------------------------------------------------------------------
// pftc_pkg
// Types, constants and rate tables shared by the pixel fade blocks.
// ---------------------------------------------------------------------------
package pftc_pkg;

	localparam int unsigned NUM_LANES = 4;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned PIXEL_W   = NUM_LANES * CHAN_W;

	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [2:0]         rate_t;
	typedef logic [3:0]         shift_t;

	localparam pixel_t HALVE_MASK = 32'h7F7F7F7F;

	// difference is carried as 10-bit signed
	localparam logic signed [9:0] SNAP_LIMIT = 10'sd3;

	// register map, decoded on paddr[2]
	typedef enum logic {
		REG_TARGET = 1'b0,
		REG_RATE   = 1'b1
	} reg_idx_t;

	localparam int unsigned ADDR_W = 3;

	function automatic shift_t shift_hi(input rate_t r);
		shift_t s;
		case (r)
			3'd0:    s = 4'd0;
			3'd1:    s = 4'd1;
			3'd2:    s = 4'd1;
			3'd3:    s = 4'd1;
			3'd4:    s = 4'd2;
			3'd5:    s = 4'd3;
			3'd6:    s = 4'd4;
			default: s = 4'd6;
		endcase
		return s;
	endfunction

	function automatic shift_t shift_lo(input rate_t r);
		shift_t s;
		case (r)
			3'd0:    s = 4'd0;
			3'd1:    s = 4'd2;
			3'd2:    s = 4'd3;
			default: s = 4'd8;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/pftc_if.sv
// ---------------------------------------------------------------------------
// pftc_if
// Valid/ready pixel channels: input and output request interfaces.
// ---------------------------------------------------------------------------
interface pftc_in_if;
	import pftc_pkg::*;
	logic   valid;
	logic   ready;
	pixel_t pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink   (input valid, input pixel_in, output ready);
endinterface

interface pftc_out_if;
	import pftc_pkg::*;
	logic   valid;
	logic   ready;
	pixel_t pixel_out;

	modport source (output valid, output pixel_out, input ready);
	modport sink   (input valid, input pixel_out, output ready);
endinterface

>>> rtl/pftc_lane.sv
// ---------------------------------------------------------------------------
// pftc_lane
// One color channel: step toward target with two floor shifts, snap when close.
// ---------------------------------------------------------------------------
module pftc_lane
	import pftc_pkg::*;
(
	input  chan_t  cur,
	input  chan_t  tgt,
	input  shift_t hs,
	input  shift_t ls,
	output chan_t  nxt
);

	logic signed [9:0]  diff;
	logic signed [10:0] step;
	logic        [10:0] sum;
	logic               snap;

	always_comb begin
		diff = $signed({2'b00, tgt}) - $signed({2'b00, cur});
		step = 11'(diff >>> hs) + 11'(diff >>> ls);
		sum  = {3'b000, cur} + step;
		snap = (diff < SNAP_LIMIT) && (diff > -SNAP_LIMIT);
		nxt  = snap ? tgt : sum[CHAN_W-1:0];
	end

endmodule

>>> rtl/pftc_merge.sv
// ---------------------------------------------------------------------------
// pftc_merge
// Packs the lane results into one pixel, or halves the input pixel in
// fade-to-black mode, and holds the result in the output register.
// ---------------------------------------------------------------------------
module pftc_merge
	import pftc_pkg::*;
(
	input  logic                 clk,
	input  logic                 load,
	input  logic                 halve,
	input  pixel_t               pixel,
	input  chan_t [NUM_LANES-1:0] lane_chan,
	output pixel_t               pixel_q
);

	pixel_t packed_px;

	always_comb begin
		packed_px = pixel_t'(lane_chan);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_q <= halve ? ((pixel >> 1) & HALVE_MASK) : packed_px;
		end
	end

endmodule

>>> rtl/pixel_fade_toward_color.sv
// ---------------------------------------------------------------------------
// pixel_fade_toward_color
// Input requests pass the input register and then the output register.
// Throughput: a pixel per cycle unless stalled; four channel lanes run in parallel.
// An input is still taken while a result waits, as long as the input stage is free.
// Reset: arst_n clears valid flags, target color and rate select to zero.
// ---------------------------------------------------------------------------
module pixel_fade_toward_color
	import pftc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	pftc_in_if.sink           pix_in,
	pftc_out_if.source        pix_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	pixel_t target_color_q;
	rate_t  rate_sel_q;
	logic   cfg_wr;

	logic   valid_s1;
	pixel_t pixel_s1;
	logic   valid_s2;
	logic   load_s2;
	logic   load_s1;

	chan_t [NUM_LANES-1:0] lane_chan;
	shift_t                hs;
	shift_t                ls;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_color_q <= '0;
			rate_sel_q     <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_TARGET: target_color_q <= pwdata;
				REG_RATE:   rate_sel_q     <= pwdata[2:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_TARGET: prdata = target_color_q;
			REG_RATE:   prdata = {29'd0, rate_sel_q};
			default:    prdata = '0;
		endcase
	end

	// pipeline control
	assign load_s2      = valid_s1 && (!valid_s2 || pix_out.ready);
	assign load_s1      = pix_in.valid && pix_in.ready;
	assign pix_in.ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (load_s2) begin
				valid_s2 <= 1'b1;
			end else if (pix_out.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			pixel_s1 <= pix_in.pixel_in;
		end
	end

	// lanes
	assign hs = shift_hi(rate_sel_q);
	assign ls = shift_lo(rate_sel_q);

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		pftc_lane u_lane (
			.cur (pixel_s1[g*CHAN_W +: CHAN_W]),
			.tgt (target_color_q[g*CHAN_W +: CHAN_W]),
			.hs  (hs),
			.ls  (ls),
			.nxt (lane_chan[g])
		);
	end

	pftc_merge u_merge (
		.clk       (clk),
		.load      (load_s2),
		.halve     (rate_sel_q == 3'd0),
		.pixel     (pixel_s1),
		.lane_chan (lane_chan),
		.pixel_q   (pix_out.pixel_out)
	);

	assign pix_out.valid = valid_s2;

endmodule

>>> dv/pixel_fade_toward_color_test.sv
// ---------------------------------------------------------------------------
// pixel_fade_toward_color_test
// Checks the one-step pixel fade against an in-bench predictor. A short table
// covers reset values, rate zero halving, snapping near the target, extreme
// differences and wide rate writes. Random phases then sweep every fade rate
// with random, all-zero and all-one targets, under random stalls on both
// request channels and one long output hold-off.
// ---------------------------------------------------------------------------
module pixel_fade_toward_color_test;
	import pftc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PHASES      = 10;
	localparam int unsigned PHASE_LEN   = 195;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned N_DIRECTED  = 17;

	// shift pairs per rate, 4 bits per entry, rate 0 in the low nibble
	localparam logic [31:0] HI_SHIFTS = {4'd6, 4'd4, 4'd3, 4'd2, 4'd1, 4'd1, 4'd1, 4'd0};
	localparam logic [31:0] LO_SHIFTS = {4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd3, 4'd2, 4'd0};

	typedef struct packed {
		logic        wr;      // program target and rate before this row
		pixel_t      target;
		logic [31:0] rate_wr;
		pixel_t      pixel;
		logic        known;   // result typed in below
		pixel_t      result;
	} fade_case_t;

	fade_case_t dir_cases [0:N_DIRECTED-1] = '{
		'{1'b0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h7F7F_7F7F},
		'{1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
		'{1'b0, 32'h0000_0000, 32'h0000_0000, 32'hAAAA_5555, 1'b1, 32'h5555_2A2A},
		'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFF8, 32'h8080_8080, 1'b1, 32'h4040_4040},
		'{1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0},
		'{1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		'{1'b1, 32'h0000_0000, 32'h0000_0002, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{1'b1, 32'h8080_8080, 32'h0000_0003, 32'h7E7F_8182, 1'b1, 32'h8080_8080},
		'{1'b0, 32'h8080_8080, 32'h0000_0003, 32'h7D7D_8383, 1'b0, 32'h0},
		'{1'b1, 32'hFF00_FF00, 32'h1234_5674, 32'h00FF_00FF, 1'b0, 32'h0},
		'{1'b1, 32'h00FF_00FF, 32'h0000_0005, 32'hFF00_FF00, 1'b0, 32'h0},
		'{1'b1, 32'h1020_3040, 32'h0000_0006, 32'h0D1D_2D3D, 1'b0, 32'h0},
		'{1'b1, 32'hFFFF_FFFF, 32'h0000_0007, 32'h0000_0000, 1'b0, 32'h0},
		'{1'b0, 32'hFFFF_FFFF, 32'h0000_0007, 32'hFCFD_FEFF, 1'b0, 32'h0},
		'{1'b1, 32'h0000_0000, 32'h0000_0007, 32'h0302_0100, 1'b0, 32'h0},
		'{1'b1, 32'h1234_5678, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 32'h1234_5678},
		'{1'b1, 32'h0000_0000, 32'h0000_0001, 32'h80FF_0102, 1'b0, 32'h0}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pftc_in_if  pix_in_bus ();
	pftc_out_if pix_out_bus ();

	pixel_fade_toward_color DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// mirror of the fade configuration
	pixel_t      tgt_m  = '0;
	rate_t       rate_m = '0;

	pixel_t      faded_q [$];
	int unsigned err_cnt      = 0;
	int unsigned results_seen = 0;
	bit          idle_on      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic pixel_t fade_step(input pixel_t px, input pixel_t tgt, input rate_t rate);
		pixel_t      res;
		int          cur;
		int          d;
		int          stepv;
		int unsigned hs;
		int unsigned ls;
		int unsigned k;
		if (rate == 3'd0)
			return (px >> 1) & HALVE_MASK;
		res = '0;
		hs  = HI_SHIFTS[rate*4 +: 4];
		ls  = LO_SHIFTS[rate*4 +: 4];
		for (k = 0; k < NUM_LANES; k++) begin
			cur = int'(px[k*CHAN_W +: CHAN_W]);
			d   = int'(tgt[k*CHAN_W +: CHAN_W]) - cur;
			if (d < 3 && d > -3)
				stepv = d;
			else
				stepv = (d >>> hs) + (d >>> ls);
			res[k*CHAN_W +: CHAN_W] = 8'(cur + stepv);
		end
		return res;
	endfunction

	function automatic void log_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("ERROR @%0t: %s", $time, msg);
	endfunction

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// block must be empty before its registers change
	task automatic drain_pipe();
		pix_in_bus.valid <= 1'b0;
		while (faded_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic program_fade(input pixel_t target, input logic [31:0] rate_wr);
		drain_pipe();
		reg_write(REG_TARGET, target);
		reg_write(REG_RATE, rate_wr);
		tgt_m  = target;
		rate_m = rate_wr[2:0];
	endtask

	task automatic offer_pixel(input pixel_t px, input logic known, input pixel_t want);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			pix_in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in_bus.valid    <= 1'b1;
		pix_in_bus.pixel_in <= px;
		do @(posedge clk); while (!pix_in_bus.ready);
		faded_q.push_back(known ? want : fade_step(px, tgt_m, rate_m));
	endtask

	// receiver: random stall bursts plus one long hold so the input backs up
	initial begin : out_side
		int unsigned hold;
		bit          long_done;
		hold      = 0;
		long_done = 1'b0;
		pix_out_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_done && results_seen >= 500) begin
				long_done = 1'b1;
				hold      = 250;
			end else if (hold == 0 && idle_on && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 10);
			end
			if (hold != 0) begin
				pix_out_bus.ready <= 1'b0;
				hold--;
			end else begin
				pix_out_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pix_out_bus.valid && pix_out_bus.ready) begin
			results_seen++;
			if (faded_q.size() == 0) begin
				log_error($sformatf("result %h with no request pending",
					pix_out_bus.pixel_out));
			end else begin
				want = faded_q.pop_front();
				if (pix_out_bus.pixel_out !== want)
					log_error($sformatf("pixel_out expected %h got %h",
						want, pix_out_bus.pixel_out));
			end
		end
	end

	always @(posedge clk) begin
		int unsigned quiet;
		if ((pix_in_bus.valid && pix_in_bus.ready) || (pix_out_bus.valid && pix_out_bus.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", STALL_LIMIT);
			$display("pixel_fade_toward_color_test failed");
			$finish;
		end
	end

	initial begin : stim
		int unsigned i;
		int unsigned p;
		int unsigned k;
		pixel_t      px;
		pixel_t      tgt;
		rate_t       rate_v;
		logic [31:0] rate_wr;

		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		pix_in_bus.valid    = 1'b0;
		pix_in_bus.pixel_in = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on = 1'b1;
		for (i = 0; i < N_DIRECTED; i++) begin
			if (dir_cases[i].wr)
				program_fade(dir_cases[i].target, dir_cases[i].rate_wr);
			offer_pixel(dir_cases[i].pixel, dir_cases[i].known, dir_cases[i].result);
		end

		for (p = 0; p < PHASES; p++) begin
			rate_v = (p < 8) ? rate_t'(p) : rate_t'($urandom_range(0, 7));
			rate_wr = $urandom_range(0, 1) ? {29'($urandom), rate_v} : {29'd0, rate_v};
			case ($urandom_range(0, 3))
				0:       tgt = 32'h0000_0000;
				1:       tgt = 32'hFFFF_FFFF;
				default: tgt = $urandom;
			endcase
			program_fade(tgt, rate_wr);
			// a quiet phase in the middle and a quiet final phase
			idle_on = (p != 3 && p != PHASES - 1);
			for (i = 0; i < PHASE_LEN; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					// land within a few codes of the target, wrapping at the ends
					for (k = 0; k < NUM_LANES; k++)
						px[k*CHAN_W +: CHAN_W] = 8'(tgt_m[k*CHAN_W +: CHAN_W]
							+ $urandom_range(0, 8) - 4);
				end else begin
					px = $urandom;
				end
				offer_pixel(px, 1'b0, '0);
			end
		end

		pix_in_bus.valid <= 1'b0;
		while (faded_q.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (err_cnt == 0) begin
			$display("pixel_fade_toward_color_test passed");
		end else begin
			$display("pixel_fade_toward_color_test failed");
		end
		$finish;
	end

endmodule

>>> pixel_fade_toward_color.f
rtl/pftc_pkg.sv
rtl/pftc_if.sv
rtl/pftc_lane.sv
rtl/pftc_merge.sv
rtl/pixel_fade_toward_color.sv
dv/pixel_fade_toward_color_test.sv
